// ===== src/indexed_pair_list_unit_defines.svh =====
`ifndef INDEXED_PAIR_LIST_UNIT_DEFINES_SVH
`define INDEXED_PAIR_LIST_UNIT_DEFINES_SVH

// same-cycle implication check
`ifndef SYNTH
`define IPL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("indexed pair list check failed");
`else
`define IPL_ASSERT_IMP(label, clk, rst, ante, cons)
`endif

// next-cycle implication check
`ifndef SYNTH
`define IPL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("indexed pair list check failed");
`else
`define IPL_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/ipl_pkg.sv =====
`default_nettype none

package ipl_pkg;

   // request kinds
   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;
   localparam logic [1:0] REQ_READ   = 2'd3;

   // response status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   // per-cell update codes
   localparam logic [1:0] CELL_HOLD  = 2'd0;
   localparam logic [1:0] CELL_LOAD  = 2'd1;
   localparam logic [1:0] CELL_LEFT  = 2'd2;
   localparam logic [1:0] CELL_RIGHT = 2'd3;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [3:0]         position;
      logic signed [31:0] first_value;
      logic [31:0]        second_value;
   } ipl_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] out_first;
      logic [31:0]        out_second;
      logic [3:0]         entry_count;
   } ipl_rsp_type;

endpackage

`default_nettype wire

// ===== src/ipl_cell.sv =====
`default_nettype none

module ipl_cell
   import ipl_pkg::*;
#(
   parameter int FIRST_WIDTH  = 32,
   parameter int SECOND_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic [1:0]              op,
   input  wire logic [FIRST_WIDTH-1:0]  load_first,
   input  wire logic [SECOND_WIDTH-1:0] load_second,
   input  wire logic [FIRST_WIDTH-1:0]  left_first,
   input  wire logic [SECOND_WIDTH-1:0] left_second,
   input  wire logic [FIRST_WIDTH-1:0]  right_first,
   input  wire logic [SECOND_WIDTH-1:0] right_second,
   output logic      [FIRST_WIDTH-1:0]  held_first,
   output logic      [SECOND_WIDTH-1:0] held_second
);

   logic [FIRST_WIDTH-1:0]  first_ff;
   logic [FIRST_WIDTH-1:0]  first_in;
   logic [SECOND_WIDTH-1:0] second_ff;
   logic [SECOND_WIDTH-1:0] second_in;

   always_comb begin
      unique case (op)
         CELL_HOLD: begin
            first_in  = first_ff;
            second_in = second_ff;
         end
         CELL_LOAD: begin
            first_in  = load_first;
            second_in = load_second;
         end
         CELL_LEFT: begin
            first_in  = left_first;
            second_in = left_second;
         end
         CELL_RIGHT: begin
            first_in  = right_first;
            second_in = right_second;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      second_ff <= second_in;
   end

   assign held_first  = first_ff;
   assign held_second = second_ff;

endmodule

`default_nettype wire

// ===== src/indexed_pair_list_unit.sv =====
`default_nettype none
`include "indexed_pair_list_unit_defines.svh"

// Ordered list of up to DEPTH pairs held in a row of cells, one pair per cell.
// A request appends, inserts at a position, removes at a position or reads at
// a position; each request gives exactly one response with a status, the
// removed or read pair (zero otherwise) and the entry count after the request.
// A full list or a bad position returns an error status and changes nothing.
// Each request completes at its transfer edge: all cells load, shift toward a neighbor or
// hold together at that edge, and the response lands in an output
// register the same edge. A new request is taken while a response waits,
// as long as the response side is not stalling, so the unit sustains one
// request per cycle. Cell contents come out of reset undefined; only
// positions below the entry count are ever read.
module indexed_pair_list_unit
   import ipl_pkg::*;
#(
   parameter int DEPTH        = 8,
   parameter int FIRST_WIDTH  = 32,
   parameter int SECOND_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire ipl_req_type req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output ipl_rsp_type      rsp_payload
);

   // count register holds 0..DEPTH; compares run at the wider of count and position
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   ipl_rsp_type      rsp_ff;
   ipl_rsp_type      rsp_in;

   logic             req_fire;
   logic [CMP_W-1:0] pos_w;
   logic [CMP_W-1:0] cnt_w;
   logic [CMP_W-1:0] cnt_next_w;
   logic             is_full;
   logic             pos_in_list;

   // decoded operation
   logic [1:0]       status;
   logic             load_en;
   logic [CMP_W-1:0] load_idx;
   logic             shr_en;
   logic             shl_en;
   logic             rd_en;
   logic             cnt_inc;
   logic             cnt_dec;

   // narrowed store values
   logic [FIRST_WIDTH+31:0]  first_zext;
   logic [SECOND_WIDTH+31:0] second_zext;
   logic [FIRST_WIDTH-1:0]   new_first;
   logic [SECOND_WIDTH-1:0]  new_second;

   // cell row
   logic [FIRST_WIDTH-1:0]  cell_first  [DEPTH];
   logic [SECOND_WIDTH-1:0] cell_second [DEPTH];
   logic [1:0]              cell_op     [DEPTH];

   // read select and output widening
   logic [FIRST_WIDTH-1:0]   rd_first;
   logic [SECOND_WIDTH-1:0]  rd_second;
   logic [FIRST_WIDTH+31:0]  rd_first_sext;
   logic [SECOND_WIDTH+31:0] rd_second_zext;

   // transfers watched by the checks
   logic             append_full_fire;
   logic             remove_fire;

   // a response stuck on a stalled output blocks the next transfer
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;

   assign pos_w       = CMP_W'(req_payload.position);
   assign cnt_w       = CMP_W'(count_ff);
   assign is_full     = (cnt_w == CMP_W'(DEPTH));
   assign pos_in_list = (pos_w < cnt_w);

   // store keeps the low bits; wider storage takes the field zero-extended
   assign first_zext  = {{FIRST_WIDTH{1'b0}}, req_payload.first_value};
   assign second_zext = {{SECOND_WIDTH{1'b0}}, req_payload.second_value};
   assign new_first   = first_zext[FIRST_WIDTH-1:0];
   assign new_second  = second_zext[SECOND_WIDTH-1:0];

   always_comb begin
      status   = ST_DONE;
      load_en  = 1'b0;
      load_idx = cnt_w;
      shr_en   = 1'b0;
      shl_en   = 1'b0;
      rd_en    = 1'b0;
      cnt_inc  = 1'b0;
      cnt_dec  = 1'b0;
      unique case (req_payload.req_type)
         REQ_APPEND: begin
            if (is_full) begin
               status = ST_FULL;
            end else begin
               load_en = 1'b1;
               cnt_inc = 1'b1;
            end
         end
         REQ_INSERT: begin
            // full is checked before the position
            priority if (is_full) begin
               status = ST_FULL;
            end else if (pos_w > cnt_w) begin
               status = ST_RANGE;
            end else begin
               load_en  = 1'b1;
               load_idx = pos_w;
               shr_en   = 1'b1;
               cnt_inc  = 1'b1;
            end
         end
         REQ_REMOVE: begin
            if (!pos_in_list) begin
               status = ST_RANGE;
            end else begin
               rd_en   = 1'b1;
               shl_en  = 1'b1;
               cnt_dec = 1'b1;
            end
         end
         REQ_READ: begin
            if (!pos_in_list) begin
               status = ST_RANGE;
            end else begin
               rd_en = 1'b1;
            end
         end
      endcase
   end

   // per-cell update: load the new pair, take the left neighbor on insert,
   // take the right neighbor on remove, else hold
   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         localparam logic [CMP_W-1:0] IDX = CMP_W'(gi);
         logic [FIRST_WIDTH-1:0]  left_first;
         logic [SECOND_WIDTH-1:0] left_second;
         logic [FIRST_WIDTH-1:0]  right_first;
         logic [SECOND_WIDTH-1:0] right_second;

         if (gi == 0) begin : g_left_edge
            assign left_first  = '0;
            assign left_second = '0;
         end else begin : g_left_link
            assign left_first  = cell_first[gi-1];
            assign left_second = cell_second[gi-1];
         end

         if (gi == DEPTH - 1) begin : g_right_edge
            assign right_first  = '0;
            assign right_second = '0;
         end else begin : g_right_link
            assign right_first  = cell_first[gi+1];
            assign right_second = cell_second[gi+1];
         end

         always_comb begin
            priority if (req_fire && load_en && IDX == load_idx) begin
               cell_op[gi] = CELL_LOAD;
            end else if (req_fire && shr_en && IDX > pos_w && IDX <= cnt_w) begin
               cell_op[gi] = CELL_LEFT;
            end else if (req_fire && shl_en && IDX >= pos_w &&
                         IDX + CMP_W'(1) < cnt_w) begin
               cell_op[gi] = CELL_RIGHT;
            end else begin
               cell_op[gi] = CELL_HOLD;
            end
         end

         ipl_cell #(
            .FIRST_WIDTH  (FIRST_WIDTH),
            .SECOND_WIDTH (SECOND_WIDTH)
         ) u_cell (
            .clock        (clock),
            .op           (cell_op[gi]),
            .load_first   (new_first),
            .load_second  (new_second),
            .left_first   (left_first),
            .left_second  (left_second),
            .right_first  (right_first),
            .right_second (right_second),
            .held_first   (cell_first[gi]),
            .held_second  (cell_second[gi])
         );
      end
   endgenerate

   // and-or select of the addressed cell, taken before the row updates
   always_comb begin
      rd_first  = '0;
      rd_second = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (pos_w == CMP_W'(i)) begin
            rd_first  = cell_first[i];
            rd_second = cell_second[i];
         end
      end
   end

   // first value is sign-extended from its stored width, then cut to 32 bits
   assign rd_first_sext  = {{32{rd_first[FIRST_WIDTH-1]}}, rd_first};
   assign rd_second_zext = {32'd0, rd_second};

   always_comb begin
      priority if (cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   assign cnt_next_w = CMP_W'(count_in);

   always_comb begin
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = status;
         rsp_in.out_first   = rd_en ? rd_first_sext[31:0] : 32'd0;
         rsp_in.out_second  = rd_en ? rd_second_zext[31:0] : 32'd0;
         rsp_in.entry_count = cnt_next_w[3:0];
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= req_fire ? count_in : count_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload needs no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign append_full_fire = req_fire && (req_payload.req_type == REQ_APPEND) && is_full;
   assign remove_fire      = req_fire && (req_payload.req_type == REQ_REMOVE) && pos_in_list;

   // entry count never passes the row length
   `IPL_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, cnt_w <= CMP_W'(DEPTH))
   // no transfer is taken while a response sits stalled
   `IPL_ASSERT_IMP(a_no_overrun, clock, reset, rsp_valid_ff && rsp_stall, !req_fire)
   // append to a full list reports full
   `IPL_ASSERT_NXT(a_full_append, clock, reset, append_full_fire, rsp_ff.status == ST_FULL)
   // a good remove shrinks the list by one
   `IPL_ASSERT_NXT(a_remove_count, clock, reset, remove_fire, count_ff == $past(count_ff) - CNT_W'(1))

endmodule

`default_nettype wire
